// ----- rtl/core/shash_pkg.sv -----
// Shared types, constants and helper functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps

package shash_pkg;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int BLOCK_BYTES  = 64;
   localparam int LEN_START    = 56;
   localparam int DIGEST_WORDS = 8;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } shash_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } shash_rsp_type;

   typedef struct packed {
      logic       en;
      logic [5:0] addr;
      logic [7:0] value;
   } shash_wr_type;

   typedef struct packed {
      logic init;
      logic step;
      logic fold;
      logic restart;
   } shash_rnd_ctl_type;

   localparam logic [31:0] IV_WORDS [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [BLOCK_BYTES] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] dbl;
      logic [63:0] shifted;
      dbl     = {x, x};
      shifted = dbl >> n;
      return shifted[31:0];
   endfunction

endpackage

// ----- rtl/core/sha256_stream_hasher_unit.sv -----
// SHA-256 stream hasher top level: byte intake, padding sequencer and digest output.
// A data beat is written into the block buffer; the beat that fills a 64-byte block starts
// compression (64 rounds of the shared round unit, then a fold into the chaining words).
// A finish beat writes padding and length one byte per cycle up to offset 63, may add
// an extra block, compresses, then sends eight digest beats, one per rsp_ready cycle.
// Reset loads the initial hash values, clears the counts and empties the output register.
`timescale 1ns / 1ps

module sha256_stream_hasher_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  shash_pkg::shash_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output shash_pkg::shash_rsp_type rsp_data
);
   import shash_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_LEN   = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_FOLD  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [1:0] RET_IDLE = 2'd0;
   localparam logic [1:0] RET_PAD  = 2'd1;
   localparam logic [1:0] RET_OUT  = 2'd2;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        ret_ff, ret_in;
   logic [5:0]        fill_ff, fill_in;
   logic [63:0]       total_ff, total_in;
   logic [63:0]       len_ff, len_in;
   logic [5:0]        rnd_ff, rnd_in;
   logic              pad_first_ff, pad_first_in;
   logic [2:0]        word_idx_ff, word_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   shash_rsp_type     rsp_ff, rsp_in;
   shash_wr_type      wr;
   shash_rnd_ctl_type rctl;
   logic              req_fire;
   logic              block_end;
   logic [31:0]       w_cur;
   logic [31:0]       chain_word;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign block_end = (fill_ff == 6'(BLOCK_BYTES - 1));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      len_in       = len_ff;
      rnd_in       = rnd_ff;
      pad_first_in = pad_first_ff;
      word_idx_in  = word_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr           = '0;
      rctl         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.kind == KIND_DATA) begin
                  wr.en    = 1'b1;
                  wr.addr  = fill_ff;
                  wr.value = req_data.data_byte;
                  fill_in  = fill_ff + 6'd1;
                  total_in = total_ff + 64'd1;
                  if (block_end) begin
                     rctl.init = 1'b1;
                     rnd_in    = '0;
                     ret_in    = RET_IDLE;
                     state_in  = ST_ROUND;
                  end
               end else begin
                  len_in       = {total_ff[60:0], 3'b000};
                  pad_first_in = 1'b1;
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wr.en        = 1'b1;
            wr.addr      = fill_ff;
            wr.value     = pad_first_ff ? PAD_BYTE : 8'h00;
            pad_first_in = 1'b0;
            fill_in      = fill_ff + 6'd1;
            if (block_end) begin
               rctl.init = 1'b1;
               rnd_in    = '0;
               ret_in    = RET_PAD;
               state_in  = ST_ROUND;
            end else if (fill_ff == 6'(LEN_START - 1)) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            wr.en    = 1'b1;
            wr.addr  = fill_ff;
            wr.value = len_ff[63:56];
            len_in   = {len_ff[55:0], 8'h00};
            fill_in  = fill_ff + 6'd1;
            if (block_end) begin
               rctl.init = 1'b1;
               rnd_in    = '0;
               ret_in    = RET_OUT;
               state_in  = ST_ROUND;
            end
         end
         ST_ROUND: begin
            rctl.step = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'(BLOCK_BYTES - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            rctl.fold   = 1'b1;
            word_idx_in = '0;
            case (ret_ff)
               RET_PAD: state_in = ST_PAD;
               RET_OUT: state_in = ST_OUT;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.digest_word = chain_word;
               rsp_in.word_index  = word_idx_ff;
               rsp_in.last        = (word_idx_ff == 3'(DIGEST_WORDS - 1));
               word_idx_in        = word_idx_ff + 3'd1;
               if (word_idx_ff == 3'(DIGEST_WORDS - 1)) begin
                  rctl.restart = 1'b1;
                  total_in     = '0;
                  fill_in      = '0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= RET_IDLE;
         fill_ff      <= '0;
         total_ff     <= '0;
         rnd_ff       <= '0;
         pad_first_ff <= 1'b0;
         word_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rnd_ff       <= rnd_in;
         pad_first_ff <= pad_first_in;
         word_idx_ff  <= word_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   shash_sched u_sched (
      .clock (clock),
      .wr    (wr),
      .shift (rctl.step),
      .w_cur (w_cur)
   );

   shash_round u_round (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rctl),
      .rnd     (rnd_ff),
      .w_cur   (w_cur),
      .rd_idx  (word_idx_ff),
      .rd_word (chain_word)
   );

   a_round_to_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'(BLOCK_BYTES - 1)) |=> (state_ff == ST_FOLD))
      else $error("Round sequence did not end in the fold step.");

   a_finish_to_pad: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.kind == KIND_FINISH) |=> (state_ff == ST_PAD && pad_first_ff))
      else $error("Finish beat did not start padding.");

   a_len_offset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (fill_ff >= 6'(LEN_START)))
      else $error("Length bytes written below their block offset.");

   a_word_idx_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_OUT) |-> (word_idx_ff == 3'd0))
      else $error("Digest word index left nonzero outside output phase.");

   a_last_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> (rsp_ff.word_index == 3'(DIGEST_WORDS - 1)))
      else $error("Last flag on a digest beat other than the final word.");

endmodule

// ----- rtl/core/shash_sched.sv -----
// Block buffer and rolling 16-word message schedule window.
`timescale 1ns / 1ps

module shash_sched (
   input  logic                   clock,
   input  shash_pkg::shash_wr_type wr,
   input  logic                   shift,
   output logic [31:0]            w_cur
);
   import shash_pkg::*;

   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] w_new;

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   assign w_new = ssig1(win_ff[14]) + win_ff[9] + ssig0(win_ff[1]) + win_ff[0];
   assign w_cur = win_ff[0];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (shift) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = w_new;
      end else if (wr.en) begin
         win_in[wr.addr[5:2]][(5'(3 - int'(wr.addr[1:0])) * 8) +: 8] = wr.value;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

endmodule

// ----- rtl/core/shash_round.sv -----
// Shared SHA-256 round unit with working variables and chaining words.
`timescale 1ns / 1ps

module shash_round (
   input  logic                        clock,
   input  logic                        reset,
   input  shash_pkg::shash_rnd_ctl_type ctl,
   input  logic [5:0]                  rnd,
   input  logic [31:0]                 w_cur,
   input  logic [2:0]                  rd_idx,
   output logic [31:0]                 rd_word
);
   import shash_pkg::*;

   logic [31:0] chain_ff [DIGEST_WORDS];
   logic [31:0] chain_in [DIGEST_WORDS];
   logic [31:0] v_ff [DIGEST_WORDS];
   logic [31:0] v_in [DIGEST_WORDS];
   logic [31:0] big_s0;
   logic [31:0] big_s1;
   logic [31:0] ch;
   logic [31:0] maj;
   logic [31:0] t1;
   logic [31:0] t2;

   assign big_s1 = rotr(v_ff[4], 5'd6) ^ rotr(v_ff[4], 5'd11) ^ rotr(v_ff[4], 5'd25);
   assign ch     = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign t1     = v_ff[7] + big_s1 + ch + ROUND_K[rnd] + w_cur;
   assign big_s0 = rotr(v_ff[0], 5'd2) ^ rotr(v_ff[0], 5'd13) ^ rotr(v_ff[0], 5'd22);
   assign maj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t2     = big_s0 + maj;
   assign rd_word = chain_ff[rd_idx];

   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         v_in[i]     = v_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (ctl.init) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            v_in[i] = chain_ff[i];
         end
      end else if (ctl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (ctl.fold) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
      end else if (ctl.restart) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_in[i] = IV_WORDS[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         v_ff[i] <= v_in[i];
      end
      if (reset) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= IV_WORDS[i];
         end
      end else begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

endmodule

// ----- dv/sha256_stream_hasher_unit_test.sv -----
// Self-checking testbench for the SHA-256 stream hasher, with a behavioral digest predictor.
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_test;
   import shash_pkg::*;

   localparam int ITEMS_TARGET = 250;
   localparam int MIN_MESSAGES = 10;
   localparam int LONG_HOLD    = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 300;
   localparam int PLAN_ROWS    = 13;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

   localparam int EDGE_LENGTHS [4] = '{55, 56, 63, 64};

   typedef struct packed {
      logic         kind;
      logic [7:0]   data_byte;
      logic         typed;
      logic [255:0] digest;
   } plan_row_type;

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{KIND_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
      '{KIND_DATA,   8'h61, 1'b0, 256'h0},
      '{KIND_DATA,   8'h62, 1'b0, 256'h0},
      '{KIND_DATA,   8'h63, 1'b0, 256'h0},
      '{KIND_FINISH, 8'hff, 1'b1, ABC_DIGEST},
      '{KIND_DATA,   8'h00, 1'b0, 256'h0},
      '{KIND_DATA,   8'hff, 1'b0, 256'h0},
      '{KIND_DATA,   8'h80, 1'b0, 256'h0},
      '{KIND_FINISH, 8'h5a, 1'b0, 256'h0},
      '{KIND_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},
      '{KIND_DATA,   8'h7f, 1'b0, 256'h0},
      '{KIND_DATA,   8'h01, 1'b0, 256'h0},
      '{KIND_FINISH, 8'h00, 1'b0, 256'h0}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   shash_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   shash_rsp_type rsp_data;

   logic [31:0] chain_state [8];
   logic [7:0]  msg_block [BLOCK_BYTES];
   int          block_fill;
   logic [63:0] msg_bytes;

   shash_rsp_type digest_words_due [$];
   int            mismatches = 0;
   int            sent_beats = 0;
   int            quiet_cycles = 0;
   int            stage = 0;
   int            tx_idle_pct = 37;
   int            rx_idle_pct = 79;
   bit            long_hold_done = 1'b0;

   sha256_stream_hasher_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void load_iv();
      for (int i = 0; i < DIGEST_WORDS; i++) chain_state[i] = IV_WORDS[i];
      block_fill = 0;
      msg_bytes  = '0;
   endfunction

   function automatic void run_rounds();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) begin
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_state[i] = chain_state[i] + v[i];
   endfunction

   function automatic void absorb_byte(input logic [7:0] value);
      msg_block[block_fill] = value;
      block_fill = block_fill + 1;
      msg_bytes  = msg_bytes + 64'd1;
      if (block_fill == BLOCK_BYTES) begin
         run_rounds();
         block_fill = 0;
      end
   endfunction

   function automatic logic [255:0] finish_message();
      logic [63:0]  bit_len;
      logic [255:0] digest;
      bit_len = msg_bytes << 3;
      msg_block[block_fill] = PAD_BYTE;
      block_fill = block_fill + 1;
      if (block_fill > LEN_START) begin
         while (block_fill < BLOCK_BYTES) begin
            msg_block[block_fill] = 8'h00;
            block_fill = block_fill + 1;
         end
         run_rounds();
         block_fill = 0;
      end
      while (block_fill < LEN_START) begin
         msg_block[block_fill] = 8'h00;
         block_fill = block_fill + 1;
      end
      for (int i = 0; i < 8; i++) msg_block[LEN_START + i] = bit_len[63 - 8*i -: 8];
      run_rounds();
      for (int i = 0; i < DIGEST_WORDS; i++) digest[255 - 32*i -: 32] = chain_state[i];
      load_iv();
      return digest;
   endfunction

   function automatic void queue_digest(input logic [255:0] digest);
      shash_rsp_type word;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         word.digest_word = digest[255 - 32*i -: 32];
         word.word_index  = 3'(i);
         word.last        = (i == DIGEST_WORDS - 1);
         digest_words_due.push_back(word);
      end
   endfunction

   task automatic set_stage(input int n);
      stage = n;
      tx_idle_pct = (n == 0) ? 37 : (n == 1) ? 79 : 0;
      rx_idle_pct = (n == 0) ? 79 : (n == 1) ? 37 : 0;
   endtask

   task automatic offer_beat(input shash_req_type beat, input logic typed,
                             input logic [255:0] typed_digest);
      logic [255:0] digest;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_beats++;
      if (beat.kind == KIND_DATA) begin
         absorb_byte(beat.data_byte);
      end else begin
         digest = finish_message();
         queue_digest(typed ? typed_digest : digest);
      end
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (stage == 2 && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      shash_rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected digest beat: word %h index %0d last %0b",
                        rsp_data.digest_word, rsp_data.word_index, rsp_data.last);
            end
         end else begin
            due = digest_words_due.pop_front();
            if (rsp_data.digest_word !== due.digest_word
                || rsp_data.word_index !== due.word_index
                || rsp_data.last !== due.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Digest beat differs: expected %h/%0d/%0b, got %h/%0d/%0b",
                           due.digest_word, due.word_index, due.last,
                           rsp_data.digest_word, rsp_data.word_index, rsp_data.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("sha256_stream_hasher_unit: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int msg_count;
      int msg_len;
      load_iv();
      set_stage(0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PLAN_ROWS; r++) begin
         offer_beat('{kind: PLAN[r].kind, data_byte: PLAN[r].data_byte},
                    PLAN[r].typed, PLAN[r].digest);
      end

      msg_count = 0;
      while (sent_beats < ITEMS_TARGET || msg_count < MIN_MESSAGES) begin
         if (sent_beats >= 2 * ITEMS_TARGET / 3) set_stage(2);
         else if (sent_beats >= ITEMS_TARGET / 3) set_stage(1);
         if (msg_count < MIN_MESSAGES && msg_count % 3 == 0) begin
            msg_len = EDGE_LENGTHS[msg_count / 3];
         end else begin
            msg_len = $urandom_range(0, 6);
         end
         for (int j = 0; j < msg_len; j++) begin
            offer_beat('{kind: KIND_DATA, data_byte: 8'($urandom_range(0, 255))}, 1'b0, '0);
         end
         offer_beat('{kind: KIND_FINISH, data_byte: 8'($urandom_range(0, 255))}, 1'b0, '0);
         msg_count++;
      end

      req_valid <= 1'b0;
      while (digest_words_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sha256_stream_hasher_unit: match");
      end else begin
         $display("sha256_stream_hasher_unit: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/shash_pkg.sv
rtl/core/shash_sched.sv
rtl/core/shash_round.sv
rtl/core/sha256_stream_hasher_unit.sv
dv/sha256_stream_hasher_unit_test.sv
